// ----- rtl/kst_pkg.sv -----
package kst_pkg;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CntW  = 32;
  localparam int unsigned SlotW = 4;

  localparam int unsigned MsPerSecond = 1000;
  localparam int unsigned RecipShift  = 38;
  localparam int unsigned RecipW      = 29;
  localparam logic [RecipW-1:0] MsRecip =
    RecipW'((64'd1 << RecipShift) / 64'(MsPerSecond) + 64'd1);
  localparam int unsigned ProdW = TimeW + RecipW;
  localparam int unsigned ElW   = ProdW - RecipShift;

  typedef enum logic [1:0] {
    OP_START,
    OP_STOP,
    OP_LOOKUP
  } kst_op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_NO_SESSION = 2'd2,
    ST_NOT_FOUND  = 2'd3
  } kst_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CLOSE,
    S_FIND,
    S_EMIT
  } kst_state_e;

  typedef struct packed {
    kst_op_e          op;
    logic [KeyW-1:0]  key;
    logic [TimeW-1:0] now;
  } kst_item_t;

endpackage

// ----- rtl/kst_front.sv -----
module kst_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [1:0]              cmd_i,
  input  logic [kst_pkg::KeyW-1:0]  key_i,
  input  logic [kst_pkg::TimeW-1:0] now_ms_i,
  output logic                    head_valid_o,
  output kst_pkg::kst_item_t      head_o,
  input  logic                    head_pop_i
);

  kst_pkg::kst_item_t fifo_q [2];
  kst_pkg::kst_item_t item;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  always_comb begin
    case (cmd_i)
      kst_pkg::OP_START: item.op = kst_pkg::OP_START;
      kst_pkg::OP_STOP:  item.op = kst_pkg::OP_STOP;
      default:           item.op = kst_pkg::OP_LOOKUP;
    endcase
    item.key = key_i;
    item.now = now_ms_i;
  end

  assign full         = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = fifo_q[rd_ptr_q];
  assign do_push      = push && !full;
  assign do_pop       = head_pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

endmodule

// ----- rtl/kst_back.sv -----
module kst_back #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      head_valid_i,
  input  kst_pkg::kst_item_t        head_i,
  output logic                      head_pop_o,
  output logic                      empty,
  input  logic                      pop,
  output logic [1:0]                status_o,
  output logic [kst_pkg::SlotW-1:0] slot_o,
  output logic [kst_pkg::CntW-1:0]  total_seconds_o,
  output logic [kst_pkg::CntW-1:0]  recency_rank_o
);

  localparam int unsigned KW = (KEY_BITS < kst_pkg::KeyW) ? KEY_BITS : kst_pkg::KeyW;
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned NW = kst_pkg::CntW;

  kst_pkg::kst_state_e state_q, state_d;
  kst_pkg::kst_op_e    op_q, op_d;
  logic [KW-1:0]       key_q, key_d;
  logic [kst_pkg::TimeW-1:0] now_q, now_d;
  logic [kst_pkg::TimeW-1:0] start_q, start_d;
  logic [CW-1:0]       count_q, count_d;
  logic                active_q, active_d;
  logic [IW-1:0]       act_slot_q, act_slot_d;
  logic [NW-1:0]       next_rank_q, next_rank_d;
  logic [NW-1:0]       rank_hold_q, rank_hold_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic                new_q, new_d;
  logic [kst_pkg::ElW-1:0] el_q, el_d;

  logic                      out_valid_q, out_valid_d;
  logic [1:0]                status_q, status_d;
  logic [kst_pkg::SlotW-1:0] slot_q, slot_d;
  logic [NW-1:0]             total_q, total_d;
  logic [NW-1:0]             rank_q, rank_d;

  logic [KW-1:0] keys_q [ENTRIES];
  logic [NW-1:0] sec_mem [ENTRIES];
  logic [NW-1:0] rank_mem [ENTRIES];
  logic [NW-1:0] sec_rd_q, rank_rd_q;

  logic [IW-1:0] rd_addr;
  logic          key_we;
  logic          sec_we;
  logic [IW-1:0] sec_wa;
  logic [NW-1:0] sec_wd;
  logic          rank_we;
  logic [IW-1:0] rank_wa;

  logic [ENTRIES-1:0] match;
  logic               hit;
  logic [IW-1:0]      hit_idx;
  logic               room;
  logic [IW-1:0]      find_idx;
  logic [kst_pkg::TimeW-1:0] elapsed;
  logic [kst_pkg::ProdW-1:0] prod;
  logic [NW:0]        sum;
  logic [NW-1:0]      sum_sat;

  always_comb begin
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      match[i] = (CW'(i) < count_q) && (keys_q[i] == key_q);
    end
    hit     = |match;
    hit_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IW'(i);
      end
    end
  end

  assign room     = (count_q < CW'(ENTRIES));
  assign find_idx = hit ? hit_idx : count_q[IW-1:0];
  assign elapsed  = now_q - start_q;
  assign prod     = elapsed * kst_pkg::MsRecip;
  assign sum      = {1'b0, sec_rd_q} + (NW + 1)'(el_q);
  assign sum_sat  = sum[NW] ? '1 : sum[NW-1:0];

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    now_d       = now_q;
    start_d     = start_q;
    count_d     = count_q;
    active_d    = active_q;
    act_slot_d  = act_slot_q;
    next_rank_d = next_rank_q;
    rank_hold_d = rank_hold_q;
    idx_d       = idx_q;
    new_d       = new_q;
    el_d        = el_q;
    out_valid_d = out_valid_q && !pop;
    status_d    = status_q;
    slot_d      = slot_q;
    total_d     = total_q;
    rank_d      = rank_q;
    head_pop_o  = 1'b0;
    rd_addr     = act_slot_q;
    key_we      = 1'b0;
    sec_we      = 1'b0;
    sec_wa      = act_slot_q;
    sec_wd      = sum_sat;
    rank_we     = 1'b0;
    rank_wa     = find_idx;

    case (state_q)
      kst_pkg::S_IDLE: begin
        if (head_valid_i && !out_valid_q) begin
          head_pop_o = 1'b1;
          op_d       = head_i.op;
          key_d      = head_i.key[KW-1:0];
          now_d      = head_i.now;
          if (head_i.op == kst_pkg::OP_STOP && !active_q) begin
            out_valid_d = 1'b1;
            status_d    = kst_pkg::ST_NO_SESSION;
            slot_d      = '0;
            total_d     = '0;
            rank_d      = '0;
          end else if (head_i.op != kst_pkg::OP_LOOKUP && active_q) begin
            state_d = kst_pkg::S_MUL;
          end else begin
            state_d = kst_pkg::S_FIND;
          end
        end
      end
      kst_pkg::S_MUL: begin
        el_d    = prod[kst_pkg::ProdW-1:kst_pkg::RecipShift];
        state_d = kst_pkg::S_CLOSE;
      end
      kst_pkg::S_CLOSE: begin
        sec_we   = 1'b1;
        active_d = 1'b0;
        if (op_q == kst_pkg::OP_STOP) begin
          out_valid_d = 1'b1;
          status_d    = kst_pkg::ST_OK;
          slot_d      = kst_pkg::SlotW'(act_slot_q);
          total_d     = sum_sat;
          rank_d      = rank_rd_q;
          state_d     = kst_pkg::S_IDLE;
        end else begin
          state_d = kst_pkg::S_FIND;
        end
      end
      kst_pkg::S_FIND: begin
        if (op_q == kst_pkg::OP_LOOKUP) begin
          new_d = 1'b0;
          if (hit) begin
            rd_addr = hit_idx;
            idx_d   = hit_idx;
            state_d = kst_pkg::S_EMIT;
          end else begin
            out_valid_d = 1'b1;
            status_d    = kst_pkg::ST_NOT_FOUND;
            slot_d      = '0;
            total_d     = '0;
            rank_d      = '0;
            state_d     = kst_pkg::S_IDLE;
          end
        end else begin
          start_d = now_q;
          if (!hit && !room) begin
            out_valid_d = 1'b1;
            status_d    = kst_pkg::ST_FULL;
            slot_d      = '0;
            total_d     = '0;
            rank_d      = '0;
            state_d     = kst_pkg::S_IDLE;
          end else begin
            if (!hit) begin
              key_we  = 1'b1;
              sec_we  = 1'b1;
              sec_wa  = find_idx;
              sec_wd  = '0;
              count_d = count_q + CW'(1);
            end
            rank_we     = 1'b1;
            rank_hold_d = next_rank_q;
            if (next_rank_q != '1) begin
              next_rank_d = next_rank_q + NW'(1);
            end
            active_d   = 1'b1;
            act_slot_d = find_idx;
            rd_addr    = find_idx;
            idx_d      = find_idx;
            new_d      = !hit;
            state_d    = kst_pkg::S_EMIT;
          end
        end
      end
      kst_pkg::S_EMIT: begin
        out_valid_d = 1'b1;
        status_d    = kst_pkg::ST_OK;
        slot_d      = kst_pkg::SlotW'(idx_q);
        total_d     = new_q ? '0 : sec_rd_q;
        rank_d      = (op_q == kst_pkg::OP_START) ? rank_hold_q : rank_rd_q;
        state_d     = kst_pkg::S_IDLE;
      end
      default: begin
        state_d = kst_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kst_pkg::S_IDLE;
      count_q     <= '0;
      active_q    <= 1'b0;
      act_slot_q  <= '0;
      start_q     <= '0;
      next_rank_q <= NW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      active_q    <= active_d;
      act_slot_q  <= act_slot_d;
      start_q     <= start_d;
      next_rank_q <= next_rank_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    now_q       <= now_d;
    rank_hold_q <= rank_hold_d;
    idx_q       <= idx_d;
    new_q       <= new_d;
    el_q        <= el_d;
    status_q    <= status_d;
    slot_q      <= slot_d;
    total_q     <= total_d;
    rank_q      <= rank_d;
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      keys_q[count_q[IW-1:0]] <= key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sec_we) begin
      sec_mem[sec_wa] <= sec_wd;
    end
    sec_rd_q <= sec_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (rank_we) begin
      rank_mem[rank_wa] <= next_rank_q;
    end
    rank_rd_q <= rank_mem[rd_addr];
  end

  assign empty           = !out_valid_q;
  assign status_o        = status_q;
  assign slot_o          = slot_q;
  assign total_seconds_o = total_q;
  assign recency_rank_o  = rank_q;

endmodule

// ----- rtl/keyed_session_time_table.sv -----
// Flow: the back-end sequencer takes a command off the queue only while its
// single-entry result register is empty, and handles one command at a time,
// so the result register must drain before the next command starts. A stop
// with no session is answered from S_IDLE; a start over an open session steps
// through S_MUL, S_CLOSE, S_FIND and S_EMIT before its result is registered.
// Reset: asynchronous, active low; table empty, no open session, next rank 1.
module keyed_session_time_table #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                cmd_i,
  input  logic [kst_pkg::KeyW-1:0]  key_i,
  input  logic [kst_pkg::TimeW-1:0] now_ms_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [1:0]                status_o,
  output logic [kst_pkg::SlotW-1:0] slot_o,
  output logic [kst_pkg::CntW-1:0]  total_seconds_o,
  output logic [kst_pkg::CntW-1:0]  recency_rank_o
);

  logic               head_valid;
  logic               head_pop;
  kst_pkg::kst_item_t head;

  kst_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .cmd_i        (cmd_i),
    .key_i        (key_i),
    .now_ms_i     (now_ms_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .head_pop_i   (head_pop)
  );

  kst_back #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .head_pop_o      (head_pop),
    .empty           (empty),
    .pop             (pop),
    .status_o        (status_o),
    .slot_o          (slot_o),
    .total_seconds_o (total_seconds_o),
    .recency_rank_o  (recency_rank_o)
  );

endmodule

// ----- rtl/kst_checker.sv -----
module kst_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  status_o,
  input logic [3:0]  slot_o,
  input logic [31:0] total_seconds_o,
  input logic [31:0] recency_rank_o
);

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != kst_pkg::ST_OK)
      |-> (slot_o == '0 && total_seconds_o == '0 && recency_rank_o == '0))
    else $error("failing status with nonzero payload");

  a_ok_ranked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == kst_pkg::ST_OK) |-> (recency_rank_o != '0))
    else $error("ok result with zero rank");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(slot_o)
      && $stable(total_seconds_o) && $stable(recency_rank_o)))
    else $error("waiting result changed");

endmodule

bind keyed_session_time_table kst_checker u_kst_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .empty           (empty),
  .pop             (pop),
  .status_o        (status_o),
  .slot_o          (slot_o),
  .total_seconds_o (total_seconds_o),
  .recency_rank_o  (recency_rank_o)
);

// ----- tb/sv/session_table_checker.sv -----
`timescale 1ns / 100ps
module session_table_checker
  import kst_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  input  logic             full,
  input  logic [1:0]       cmd_i,
  input  logic [KeyW-1:0]  key_i,
  input  logic [TimeW-1:0] now_ms_i,
  input  logic             empty,
  input  logic             pop,
  input  logic [1:0]       status_i,
  input  logic [SlotW-1:0] slot_i,
  input  logic [CntW-1:0]  total_seconds_i,
  input  logic [CntW-1:0]  recency_rank_i,
  output int               error_count_o,
  output int               pending_o
);

  localparam int unsigned Slots = 16;

  typedef struct packed {
    logic [1:0]       status;
    logic [SlotW-1:0] slot;
    logic [CntW-1:0]  seconds;
    logic [CntW-1:0]  rank;
  } answer_t;

  logic [KeyW-1:0]  key_tab  [Slots];
  logic [CntW-1:0]  secs_tab [Slots];
  logic [CntW-1:0]  rank_tab [Slots];
  int unsigned      used;
  logic             session_open;
  int unsigned      open_slot;
  logic [TimeW-1:0] t_start;
  logic [CntW-1:0]  rank_next;
  answer_t          answer_q [$];
  int               errs;

  function automatic int find_key(logic [KeyW-1:0] k);
    for (int i = 0; i < used; i++) begin
      if (key_tab[i] == k) return i;
    end
    return -1;
  endfunction

  // add whole seconds since the session start, wrap-safe, saturating
  function automatic void close_session(logic [TimeW-1:0] now);
    logic [CntW-1:0] el;
    if (!session_open) return;
    el = (now - t_start) / MsPerSecond;
    if (secs_tab[open_slot] > {CntW{1'b1}} - el) secs_tab[open_slot] = '1;
    else secs_tab[open_slot] = secs_tab[open_slot] + el;
    session_open = 1'b0;
  endfunction

  function automatic answer_t reply(logic [1:0] st, int idx);
    answer_t a;
    a = '0;
    a.status = st;
    if (idx >= 0) begin
      a.slot    = SlotW'(idx);
      a.seconds = secs_tab[idx];
      a.rank    = rank_tab[idx];
    end
    return a;
  endfunction

  function automatic answer_t session_answer(logic [1:0] op, logic [KeyW-1:0] k,
                                             logic [TimeW-1:0] now);
    int idx;
    if (op == OP_START) begin
      close_session(now);
      idx = find_key(k);
      if (idx < 0 && used < Slots) begin
        idx = used;
        key_tab[idx]  = k;
        secs_tab[idx] = '0;
        rank_tab[idx] = '0;
        used++;
      end
      t_start = now;
      if (idx < 0) return reply(ST_FULL, -1);
      rank_tab[idx] = rank_next;
      if (rank_next != '1) rank_next++;
      session_open = 1'b1;
      open_slot    = idx;
      return reply(ST_OK, idx);
    end
    if (op == OP_STOP) begin
      if (!session_open) return reply(ST_NO_SESSION, -1);
      idx = open_slot;
      close_session(now);
      return reply(ST_OK, idx);
    end
    idx = find_key(k);
    if (idx < 0) return reply(ST_NOT_FOUND, -1);
    return reply(ST_OK, idx);
  endfunction

  task automatic check_field(input string name, input logic [CntW-1:0] want,
                             input logic [CntW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    answer_t want;
    if (!rst_ni) begin
      used         = 0;
      session_open = 1'b0;
      open_slot    = 0;
      t_start      = '0;
      rank_next    = 1;
      answer_q.delete();
      errs         = 0;
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      if (push && !full) answer_q.push_back(session_answer(cmd_i, key_i, now_ms_i));
      if (pop && !empty) begin
        if (answer_q.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d slot %0d seconds %0d rank %0d",
                   $time, status_i, slot_i, total_seconds_i, recency_rank_i);
          errs++;
        end else begin
          want = answer_q.pop_front();
          check_field("status", want.status, status_i);
          check_field("slot", want.slot, slot_i);
          check_field("total_seconds", want.seconds, total_seconds_i);
          check_field("recency_rank", want.rank, recency_rank_i);
        end
      end
      error_count_o <= errs;
      pending_o     <= answer_q.size();
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
module tb;
  import kst_pkg::*;

  localparam logic [1:0] OpSpare = 2'd3;

  logic              clk_i    = 1'b0;
  logic              rst_ni   = 1'b0;
  logic              push     = 1'b0;
  logic              pop      = 1'b0;
  logic [1:0]        cmd_i    = '0;
  logic [KeyW-1:0]   key_i    = '0;
  logic [TimeW-1:0]  now_ms_i = '0;
  logic              full;
  logic              empty;
  logic [1:0]        status_o;
  logic [SlotW-1:0]  slot_o;
  logic [CntW-1:0]   total_seconds_o;
  logic [CntW-1:0]   recency_rank_o;
  int                errs;
  int                pending;
  int                send_idle  = 0;
  int                recv_stall = 0;
  logic [KeyW-1:0]   known_keys [16];
  logic [TimeW-1:0]  clock_ms;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  keyed_session_time_table dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .cmd_i           (cmd_i),
    .key_i           (key_i),
    .now_ms_i        (now_ms_i),
    .empty           (empty),
    .pop             (pop),
    .status_o        (status_o),
    .slot_o          (slot_o),
    .total_seconds_o (total_seconds_o),
    .recency_rank_o  (recency_rank_o)
  );

  session_table_checker table_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .cmd_i           (cmd_i),
    .key_i           (key_i),
    .now_ms_i        (now_ms_i),
    .empty           (empty),
    .pop             (pop),
    .status_i        (status_o),
    .slot_i          (slot_o),
    .total_seconds_i (total_seconds_o),
    .recency_rank_i  (recency_rank_o),
    .error_count_o   (errs),
    .pending_o       (pending)
  );

  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= recv_stall);
  end

  // hold the command until the queue takes it
  task automatic send(input logic [1:0] op, input logic [KeyW-1:0] k,
                      input logic [TimeW-1:0] t);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push     <= 1'b1;
    cmd_i    <= op;
    key_i    <= k;
    now_ms_i <= t;
    do @(posedge clk_i); while (full);
  endtask

  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    int r;
    logic [1:0] op;
    logic [KeyW-1:0] k;
    int stall_of [4];
    int idle_of [4];
    idle_of  = '{0, 69, 0, 28};
    stall_of = '{0, 0, 69, 28};
    known_keys[0] = '0;
    known_keys[1] = '1;
    known_keys[2] = 32'hA5A5_A5A5;
    for (int i = 3; i < 16; i++) known_keys[i] = $urandom;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    send(OP_STOP, '1, 32'd5);
    send(OP_LOOKUP, known_keys[0], '0);
    send(OP_START, known_keys[0], '0);
    send(OP_STOP, '0, 32'd1999);
    send(OP_START, known_keys[1], 32'hFFFF_FC18);
    send(OpSpare, known_keys[1], '0);
    // close the open session across the time wrap
    send(OP_START, known_keys[0], 32'h0000_0BB7);
    send(OP_STOP, '0, 32'h8000_0BB7);
    send(OP_START, known_keys[2], '1);
    send(OP_STOP, '1, 32'hFFFF_FFFE);
    for (int i = 3; i < 16; i++) send(OP_START, known_keys[i], 32'h0100_0000 * i);
    send(OP_START, ~known_keys[2], 32'h7FFF_FFFF);
    send(OP_STOP, '0, '1);
    send(OpSpare, 32'h1234_5678, '0);

    clock_ms = $urandom;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = idle_of[ph];
      recv_stall = stall_of[ph];
      repeat (285) begin
        r = $urandom_range(99);
        if (r < 40) op = OP_START;
        else if (r < 72) op = OP_STOP;
        else if (r < 95) op = OP_LOOKUP;
        else op = OpSpare;
        if ($urandom_range(99) < 85) k = known_keys[$urandom_range(15)];
        else k = $urandom;
        r = $urandom_range(99);
        if (r < 80) clock_ms += $urandom_range(30000);
        else if (r < 95) clock_ms += $urandom_range(5000000);
        else clock_ms = $urandom;
        send(op, k, clock_ms);
      end
    end

    @(negedge clk_i) push <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errs == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/kst_pkg.sv
rtl/kst_front.sv
rtl/kst_back.sv
rtl/keyed_session_time_table.sv
rtl/kst_checker.sv
tb/sv/session_table_checker.sv
tb/sv/tb.sv
